/* hdl/ccs_pkg.sv */
`default_nettype none
package ccs_pkg;

  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_BSLASH = 8'h5C;

  localparam int QDepth = 2;
  localparam int QPtrW  = $clog2(QDepth);
  localparam int QCntW  = $clog2(QDepth + 1);

  typedef enum logic [3:0] {
    ST_NORMAL    = 4'd0,
    ST_SLASH     = 4'd1,
    ST_BLOCK     = 4'd2,
    ST_BLOCKSTAR = 4'd3,
    ST_LINE      = 4'd4,
    ST_STR       = 4'd5,
    ST_STR_ESC   = 4'd6,
    ST_CHR       = 4'd7,
    ST_CHR_ESC   = 4'd8
  } scan_t;

  // results caused by one input byte: one or two output beats
  typedef struct packed {
    logic       two;
    logic [7:0] b0;
    logic       v0;
    logic [7:0] b1;
    logic       last;
  } ccs_entry_t;

  typedef struct packed {
    logic       valid;
    ccs_entry_t entry;
  } ccs_push_t;

  typedef struct packed {
    logic       valid;
    ccs_entry_t entry;
  } ccs_head_t;

endpackage
`default_nettype wire

/* hdl/ccs_front.sv */
`default_nettype none
module ccs_front (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire logic [7:0]    in_byte,
  input  wire logic          in_end_of_text,
  input  wire logic          q_full,
  output ccs_pkg::ccs_push_t push
);
  import ccs_pkg::*;

  scan_t      state_r;
  scan_t      state_nxt;
  logic [1:0] cnt;
  logic       accept;
  ccs_entry_t ent;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_nxt = state_r;
    cnt       = 2'd0;
    ent.two   = 1'b0;
    ent.b0    = '0;
    ent.v0    = 1'b1;
    ent.b1    = '0;
    ent.last  = in_end_of_text;
    unique case (state_r)
      ST_SLASH: begin
        if (in_byte == CH_STAR) begin
          state_nxt = ST_BLOCK;
        end else if (in_byte == CH_SLASH) begin
          state_nxt = ST_LINE;
        end else begin
          // release the held slash ahead of this byte
          cnt    = 2'd2;
          ent.b0 = CH_SLASH;
          ent.b1 = in_byte;
          if (in_byte == CH_DQUOTE) begin
            state_nxt = ST_STR;
          end else if (in_byte == CH_SQUOTE) begin
            state_nxt = ST_CHR;
          end else begin
            state_nxt = ST_NORMAL;
          end
        end
      end
      ST_BLOCK: begin
        if (in_byte == CH_STAR) state_nxt = ST_BLOCKSTAR;
      end
      ST_BLOCKSTAR: begin
        if (in_byte == CH_SLASH) begin
          state_nxt = ST_NORMAL;
        end else if (in_byte != CH_STAR) begin
          state_nxt = ST_BLOCK;
        end
      end
      ST_LINE: begin
        if (in_byte == CH_NL) begin
          cnt       = 2'd1;
          ent.b0    = in_byte;
          state_nxt = ST_NORMAL;
        end
      end
      ST_STR: begin
        cnt    = 2'd1;
        ent.b0 = in_byte;
        if (in_byte == CH_BSLASH) begin
          state_nxt = ST_STR_ESC;
        end else if (in_byte == CH_DQUOTE) begin
          state_nxt = ST_NORMAL;
        end
      end
      ST_STR_ESC: begin
        cnt       = 2'd1;
        ent.b0    = in_byte;
        state_nxt = ST_STR;
      end
      ST_CHR: begin
        cnt    = 2'd1;
        ent.b0 = in_byte;
        if (in_byte == CH_BSLASH) begin
          state_nxt = ST_CHR_ESC;
        end else if (in_byte == CH_SQUOTE) begin
          state_nxt = ST_NORMAL;
        end
      end
      ST_CHR_ESC: begin
        cnt       = 2'd1;
        ent.b0    = in_byte;
        state_nxt = ST_CHR;
      end
      default: begin
        if (in_byte == CH_SLASH) begin
          state_nxt = ST_SLASH;
        end else begin
          cnt    = 2'd1;
          ent.b0 = in_byte;
          if (in_byte == CH_DQUOTE) begin
            state_nxt = ST_STR;
          end else if (in_byte == CH_SQUOTE) begin
            state_nxt = ST_CHR;
          end else begin
            state_nxt = ST_NORMAL;
          end
        end
      end
    endcase

    if (in_end_of_text) begin
      // a held slash can only come with no other result
      if (state_nxt == ST_SLASH) begin
        cnt    = 2'd1;
        ent.b0 = CH_SLASH;
      end
      // bare end marker
      if (cnt == 2'd0) begin
        cnt    = 2'd1;
        ent.b0 = '0;
        ent.v0 = 1'b0;
      end
      state_nxt = ST_NORMAL;
    end
    ent.two = (cnt == 2'd2);
  end

  assign push.valid = accept && (cnt != 2'd0);
  assign push.entry = ent;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_NORMAL;
    end else if (accept) begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

/* hdl/ccs_queue.sv */
`default_nettype none
module ccs_queue (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire ccs_pkg::ccs_push_t push,
  output logic               q_full,
  output ccs_pkg::ccs_head_t head,
  input  wire logic          pop
);
  import ccs_pkg::*;

  ccs_entry_t             mem_r [QDepth];
  logic [QPtrW-1:0]       wptr_r;
  logic [QPtrW-1:0]       rptr_r;
  logic [QCntW-1:0]       cnt_r;
  logic                   do_push;
  logic                   do_pop;

  assign q_full     = (cnt_r == QCntW'(QDepth));
  assign head.valid = (cnt_r != '0);
  assign head.entry = mem_r[rptr_r];
  assign do_push    = push.valid && !q_full;
  assign do_pop     = pop && head.valid;

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wptr_r] <= push.entry;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (do_push) wptr_r <= (wptr_r == QPtrW'(QDepth - 1)) ? '0 : wptr_r + 1'b1;
      if (do_pop)  rptr_r <= (rptr_r == QPtrW'(QDepth - 1)) ? '0 : rptr_r + 1'b1;
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

/* hdl/ccs_back.sv */
`default_nettype none
module ccs_back (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire ccs_pkg::ccs_head_t head,
  output logic               pop,
  output logic               out_valid,
  input  wire logic          out_ready,
  output logic [7:0]         out_byte,
  output logic               out_byte_valid,
  output logic               out_last_result
);
  import ccs_pkg::*;

  logic       out_valid_r;
  logic [7:0] byte_r;
  logic       bvalid_r;
  logic       last_r;
  logic       half_r;
  logic       load;
  logic       take;

  // output register refills whenever it is empty or being drained
  assign load = !out_valid_r || out_ready;
  assign take = load && head.valid;
  assign pop  = take && (half_r || !head.entry.two);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      half_r      <= 1'b0;
    end else if (load) begin
      out_valid_r <= head.valid;
      if (take) half_r <= head.entry.two && !half_r;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      if (half_r) begin
        byte_r   <= head.entry.b1;
        bvalid_r <= 1'b1;
        last_r   <= head.entry.last;
      end else begin
        byte_r   <= head.entry.b0;
        bvalid_r <= head.entry.v0;
        last_r   <= head.entry.last && !head.entry.two;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_byte        = byte_r;
  assign out_byte_valid  = bvalid_r;
  assign out_last_result = last_r;

endmodule
`default_nettype wire

/* hdl/c_comment_stripper_unit.sv */
`default_nettype none
// channel   ports                                  direction
// in        in_valid/in_ready, in_byte,            input, one source byte a beat
//           in_end_of_text
// out       out_valid/out_ready, out_byte,         output, one kept byte or end marker
//           out_byte_valid, out_last_result
//
// one input byte per cycle; a byte that releases a held slash yields two output
// beats, and the output register drains one beat per cycle from a 2-entry queue.
// an accepted byte's result is written into the queue, then loaded into the output register.
// rst_n (synchronous) returns the scanner to normal code and empties the queue.
// in_ready drops only while the queue is full; out_ready low stalls the back end.
module c_comment_stripper_unit (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_byte,
  input  wire logic       in_end_of_text,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_byte,
  output logic            out_byte_valid,
  output logic            out_last_result
);
  import ccs_pkg::*;

  ccs_push_t push;
  ccs_head_t head;
  logic      q_full;
  logic      pop;

  ccs_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_byte        (in_byte),
    .in_end_of_text (in_end_of_text),
    .q_full         (q_full),
    .push           (push)
  );

  ccs_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .q_full (q_full),
    .head   (head),
    .pop    (pop)
  );

  ccs_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head            (head),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_byte        (out_byte),
    .out_byte_valid  (out_byte_valid),
    .out_last_result (out_last_result)
  );

endmodule
`default_nettype wire

/* test/c_comment_stripper_unit_test.sv */
`default_nettype none
module c_comment_stripper_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import ccs_pkg::*;

  localparam int NumSrcBytes = 1150;
  localparam int IdleLimit   = 2000;
  localparam int SettleTicks = 16;
  localparam int MaxWait     = 17;

  typedef struct {
    logic [7:0]  ch;
    logic        eot;
    int unsigned gap;
    bit          drain_first;
  } src_char_t;

  typedef struct {
    logic [7:0] ch;
    logic       has_char;
    logic       last;
  } kept_char_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_byte = 8'h00;
  logic       in_end_of_text = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_byte;
  logic       out_byte_valid;
  logic       out_last_result;

  src_char_t  src_q[$];
  kept_char_t kept_q[$];
  kept_char_t step_res[$];
  scan_t      scanner = ST_NORMAL;

  int          send_wait = 0;
  int          stall_left = 0;
  int          idle_cycles = 0;
  int          mismatches = 0;
  int          bytes_sent = 0;
  int          beats_seen = 0;
  int          bare_markers = 0;
  int          texts_built = 0;
  src_char_t   next_src;
  kept_char_t  got_exp;

  c_comment_stripper_unit dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_byte         (in_byte),
    .in_end_of_text  (in_end_of_text),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_byte        (out_byte),
    .out_byte_valid  (out_byte_valid),
    .out_last_result (out_last_result)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // ---------------- expected output of the comment scanner ----------------

  function automatic void keep_char(logic [7:0] c);
    step_res.push_back('{ch: c, has_char: 1'b1, last: 1'b0});
  endfunction

  function automatic void code_char(logic [7:0] c);
    if (c == CH_SLASH) begin
      scanner = ST_SLASH;
    end else begin
      keep_char(c);
      if (c == CH_DQUOTE) scanner = ST_STR;
      else if (c == CH_SQUOTE) scanner = ST_CHR;
      else scanner = ST_NORMAL;
    end
  endfunction

  function automatic void strip_predict(logic [7:0] c, logic eot);
    kept_char_t r;
    step_res.delete();
    case (scanner)
      ST_SLASH: begin
        if (c == CH_STAR) scanner = ST_BLOCK;
        else if (c == CH_SLASH) scanner = ST_LINE;
        else begin
          // held slash goes out ahead of this byte
          keep_char(CH_SLASH);
          code_char(c);
        end
      end
      ST_BLOCK: begin
        if (c == CH_STAR) scanner = ST_BLOCKSTAR;
      end
      ST_BLOCKSTAR: begin
        if (c == CH_SLASH) scanner = ST_NORMAL;
        else if (c != CH_STAR) scanner = ST_BLOCK;
      end
      ST_LINE: begin
        if (c == CH_NL) begin
          keep_char(c);
          scanner = ST_NORMAL;
        end
      end
      ST_STR: begin
        keep_char(c);
        if (c == CH_BSLASH) scanner = ST_STR_ESC;
        else if (c == CH_DQUOTE) scanner = ST_NORMAL;
      end
      ST_STR_ESC: begin
        keep_char(c);
        scanner = ST_STR;
      end
      ST_CHR: begin
        keep_char(c);
        if (c == CH_BSLASH) scanner = ST_CHR_ESC;
        else if (c == CH_SQUOTE) scanner = ST_NORMAL;
      end
      ST_CHR_ESC: begin
        keep_char(c);
        scanner = ST_CHR;
      end
      default: code_char(c);
    endcase
    if (eot) begin
      if (scanner == ST_SLASH) keep_char(CH_SLASH);
      if (step_res.size() == 0) step_res.push_back('{ch: 8'h00, has_char: 1'b0, last: 1'b0});
      r = step_res.pop_back();
      r.last = 1'b1;
      step_res.push_back(r);
      scanner = ST_NORMAL;
    end
    foreach (step_res[i]) kept_q.push_back(step_res[i]);
  endfunction

  // ---------------- source text generation ----------------

  function automatic void push_char(logic [7:0] c, logic eot);
    src_char_t s;
    bit calm;
    calm = ((src_q.size() / 80) % 3) == 2;
    s.ch = c;
    s.eot = eot;
    s.gap = calm ? 0 : $urandom_range(0, MaxWait);
    s.drain_first = (src_q.size() % 300) == 25;
    src_q.push_back(s);
    if (eot) texts_built++;
  endfunction

  function automatic void add_text(string t, logic eot_at_end);
    for (int i = 0; i < t.len(); i++) push_char(t[i], eot_at_end && (i == t.len() - 1));
  endfunction

  function automatic logic [7:0] body_char();
    case ($urandom_range(0, 9))
      0: return CH_STAR;
      1: return CH_SLASH;
      2: return CH_DQUOTE;
      3: return CH_SQUOTE;
      4: return CH_BSLASH;
      5: return CH_NL;
      6, 7: return 8'h61 + 8'($urandom_range(0, 25));
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic void add_token();
    case ($urandom_range(0, 11))
      0, 1, 2: repeat ($urandom_range(1, 4)) push_char(body_char(), 1'b0);
      3: begin
        push_char(CH_SLASH, 1'b0);
        push_char(CH_STAR, 1'b0);
        repeat ($urandom_range(0, 6)) push_char(body_char(), 1'b0);
        // most block comments get closed, sometimes with a run of stars
        if ($urandom_range(0, 4) != 0) begin
          repeat ($urandom_range(1, 3)) push_char(CH_STAR, 1'b0);
          push_char(CH_SLASH, 1'b0);
        end
      end
      4: begin
        push_char(CH_SLASH, 1'b0);
        push_char(CH_SLASH, 1'b0);
        repeat ($urandom_range(0, 6)) push_char(body_char(), 1'b0);
        push_char(CH_NL, 1'b0);
      end
      5, 6: begin
        push_char(CH_DQUOTE, 1'b0);
        repeat ($urandom_range(0, 6)) begin
          if ($urandom_range(0, 3) == 0) push_char(CH_BSLASH, 1'b0);
          push_char(body_char(), 1'b0);
        end
        push_char(CH_DQUOTE, 1'b0);
      end
      7: begin
        push_char(CH_SQUOTE, 1'b0);
        if ($urandom_range(0, 1) == 1) push_char(CH_BSLASH, 1'b0);
        push_char(body_char(), 1'b0);
        push_char(CH_SQUOTE, 1'b0);
      end
      8, 9: begin
        push_char(CH_SLASH, 1'b0);
        case ($urandom_range(0, 2))
          0: push_char(CH_DQUOTE, 1'b0);
          1: push_char(CH_SQUOTE, 1'b0);
          default: push_char(body_char(), 1'b0);
        endcase
      end
      10: repeat ($urandom_range(1, 4)) push_char(8'($urandom_range(0, 255)), 1'b0);
      default: begin
        push_char(CH_STAR, 1'b0);
        push_char(CH_SLASH, 1'b0);
      end
    endcase
  endfunction

  function automatic void add_random_text();
    src_char_t s;
    repeat ($urandom_range(1, 8)) add_token();
    s = src_q.pop_back();
    s.eot = 1'b1;
    src_q.push_back(s);
    texts_built++;
  endfunction

  // ---------------- driver ----------------

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_byte <= 8'h00;
      in_end_of_text <= 1'b0;
      send_wait = 0;
    end else begin
      if (in_valid && in_ready) begin
        strip_predict(in_byte, in_end_of_text);
        bytes_sent++;
      end
      if (!in_valid || in_ready) begin
        if (src_q.size() == 0) begin
          in_valid <= 1'b0;
        end else if (src_q[0].drain_first && kept_q.size() != 0) begin
          // hold off until the block has handed back everything
          in_valid <= 1'b0;
        end else if (send_wait < src_q[0].gap) begin
          send_wait++;
          in_valid <= 1'b0;
        end else begin
          next_src = src_q.pop_front();
          send_wait = 0;
          in_valid <= 1'b1;
          in_byte <= next_src.ch;
          in_end_of_text <= next_src.eot;
        end
      end
    end
  end

  // ---------------- monitor ----------------

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && out_ready) begin
        beats_seen++;
        if (!out_byte_valid) bare_markers++;
        if (kept_q.size() == 0) begin
          $error("beat with nothing expected: out_byte=%h out_byte_valid=%b out_last_result=%b",
                 out_byte, out_byte_valid, out_last_result);
          mismatches++;
        end else begin
          got_exp = kept_q.pop_front();
          if (out_byte !== got_exp.ch) begin
            $error("out_byte: expected %h, got %h", got_exp.ch, out_byte);
            mismatches++;
          end
          if (out_byte_valid !== got_exp.has_char) begin
            $error("out_byte_valid: expected %b, got %b", got_exp.has_char, out_byte_valid);
            mismatches++;
          end
          if (out_last_result !== got_exp.last) begin
            $error("out_last_result: expected %b, got %b", got_exp.last, out_last_result);
            mismatches++;
          end
        end
        stall_left = (((beats_seen / 70) % 3) == 1) ? 0 : $urandom_range(0, MaxWait);
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  // ---------------- stimulus and end of run ----------------

  initial begin
    bit timed_out;
    timed_out = 1'b0;

    // extremes, block comment closed by a run of stars, line comment keeping its newline
    push_char(8'hFF, 1'b0);
    add_text("/*", 1'b0);
    push_char(8'h00, 1'b0);
    add_text("**/", 1'b0);
    add_text("//c\n", 1'b0);
    // slash released ahead of a quote, escaped quote inside the string
    add_text("/\"\\\"\"", 1'b0);
    // escaped quote in a character constant
    add_text("'\\''", 1'b0);
    // string cut off by the end of text
    add_text("\"x", 1'b1);
    // end of text with a slash held
    add_text("/", 1'b1);
    // end of text inside a comment: bare end marker
    add_text("/*", 1'b1);

    while (src_q.size() < NumSrcBytes) add_random_text();

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    while (!timed_out && (src_q.size() != 0 || in_valid || kept_q.size() != 0)) begin
      @(posedge clk);
      if (idle_cycles >= IdleLimit) timed_out = 1'b1;
    end
    if (!timed_out) repeat (SettleTicks) @(posedge clk);

    if (kept_q.size() != 0) begin
      $error("%0d expected beats never arrived", kept_q.size());
      mismatches++;
    end

    if (timed_out) begin
      $display("timeout: no beat moved for %0d cycles", IdleLimit);
      $display("c_comment_stripper_unit_test NOT OK");
    end else begin
      $display("covered %0d source bytes in %0d texts with comments, strings and char constants",
               bytes_sent, texts_built);
      $display("checked %0d output beats, %0d of them bare end markers", beats_seen, bare_markers);
      if (mismatches == 0) begin
        $display("c_comment_stripper_unit_test OK");
      end else begin
        $display("c_comment_stripper_unit_test NOT OK");
      end
    end
    $finish;
  end

endmodule
`default_nettype wire
